FILE: design/fsp_pkg.sv
package fsp_pkg;

  // parse phases of one conversion request
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_FLAG   = 4'd1,
    PH_WSTART = 4'd2,
    PH_WDIG   = 4'd3,
    PH_DOT    = 4'd4,
    PH_PSTART = 4'd5,
    PH_PDIG   = 4'd6,
    PH_LEN    = 4'd7,
    PH_LEN_L  = 4'd8,
    PH_LEN_H  = 4'd9,
    PH_SPEC   = 4'd10
  } phase_t;

  // result status codes
  localparam logic STAT_PARSED  = 1'b0;
  localparam logic STAT_NOT_REQ = 1'b1;

  // flag codes
  localparam logic [2:0] FLAG_NONE  = 3'd0;
  localparam logic [2:0] FLAG_MINUS = 3'd1;
  localparam logic [2:0] FLAG_PLUS  = 3'd2;
  localparam logic [2:0] FLAG_SPACE = 3'd3;
  localparam logic [2:0] FLAG_HASH  = 3'd4;
  localparam logic [2:0] FLAG_ZERO  = 3'd5;

  // length modifier codes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_LL   = 3'd1;
  localparam logic [2:0] LEN_L    = 3'd2;
  localparam logic [2:0] LEN_HH   = 3'd3;
  localparam logic [2:0] LEN_H    = 3'd4;
  localparam logic [2:0] LEN_J    = 3'd5;
  localparam logic [2:0] LEN_Z    = 3'd6;
  localparam logic [2:0] LEN_Q    = 3'd7;

  // characters of the request syntax
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_L       = 8'h6c;
  localparam logic [7:0] CH_H       = 8'h68;
  localparam logic [7:0] CH_J       = 8'h6a;
  localparam logic [7:0] CH_Z       = 8'h7a;
  localparam logic [7:0] CH_Q       = 8'h71;

  // packed width of one result item and its byte-padded bus width
  localparam int RES_BITS  = 49;
  localparam int RES_BYTES = (RES_BITS + 7) / 8;
  localparam int OUT_W     = RES_BYTES * 8;

  // one result item, first field in the highest bits
  typedef struct packed {
    logic [7:0]  conversion;
    logic [2:0]  length_code;
    logic        precision_from_arg;
    logic [15:0] precision;
    logic        width_from_arg;
    logic [15:0] width;
    logic [2:0]  flag_code;
    logic        status;
  } result_t;

  // flag character to flag code
  function automatic logic [2:0] flag_of(input logic [7:0] c);
    logic [2:0] f;
    f = FLAG_NONE;
    if (c == CH_MINUS) f = FLAG_MINUS;
    if (c == CH_PLUS)  f = FLAG_PLUS;
    if (c == CH_SPACE) f = FLAG_SPACE;
    if (c == CH_HASH)  f = FLAG_HASH;
    if (c == CH_ZERO)  f = FLAG_ZERO;
    return f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: design/fsp_dec_acc.sv
module fsp_dec_acc #(
  parameter int NUM_WIDTH = 16
) (
  input  logic [NUM_WIDTH-1:0] base,
  input  logic [3:0]           digit,
  output logic [NUM_WIDTH-1:0] sum
);

  localparam int PW = NUM_WIDTH + 4;

  logic [PW-1:0] base_x;
  logic [PW-1:0] prod;
  logic [PW-1:0] max_x;

  // base * 10 + digit, held at the all-ones maximum
  assign base_x = {4'b0, base};
  assign prod   = (base_x << 3) + (base_x << 1) + {{NUM_WIDTH{1'b0}}, digit};
  assign max_x  = {4'b0, {NUM_WIDTH{1'b1}}};
  assign sum    = (prod > max_x) ? {NUM_WIDTH{1'b1}} : prod[NUM_WIDTH-1:0];

endmodule

FILE: design/format_specifier_parser_unit.sv
// a byte waits in the input register; its result item enters the output register when that stage advances
// throughput: one byte per cycle when not stalled; the parse state updates once per byte in a single pass
// a stalled result holds the input stage only when that stage's byte also yields a result
// reset: synchronous active-low rst_n empties both stages and returns the parser to idle
// with all collected fields cleared
module format_specifier_parser_unit #(
  parameter int NUM_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // ch[7:0]
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // status[0], flag_code[3:1], width[19:4], width_from_arg[20], precision[36:21],
  // precision_from_arg[37], length_code[40:38], conversion[48:41], zero pad above
  output logic [fsp_pkg::OUT_W-1:0] out_tdata
);
  import fsp_pkg::*;

  localparam int EXT_W = NUM_WIDTH + 16;

  // input stage
  logic       stage_valid_r;
  logic [7:0] ch_r;
  logic       stage_adv;

  // parse state
  phase_t               phase_r, phase_nxt;
  logic [2:0]           flag_r, flag_nxt;
  logic [NUM_WIDTH-1:0] wacc_r, wacc_nxt;
  logic                 wstar_r, wstar_nxt;
  logic [NUM_WIDTH-1:0] pacc_r, pacc_nxt;
  logic                 pstar_r, pstar_nxt;
  logic [2:0]           len_r, len_nxt;

  // result stage
  logic       out_valid_r;
  result_t    res_r, res_nxt;
  logic       out_free;

  logic       emit;
  logic       not_req;

  // shared decimal accumulator
  logic                 prec_side;
  logic [NUM_WIDTH-1:0] acc_base;
  logic [NUM_WIDTH-1:0] acc_sum;
  logic [EXT_W-1:0]     wacc_ext;
  logic [EXT_W-1:0]     pacc_ext;

  // handshake
  assign out_free   = !out_valid_r || out_tready;
  assign stage_adv  = stage_valid_r && (!emit || out_free);
  assign in_tready  = !stage_valid_r || stage_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - RES_BITS){1'b0}}, res_r};

  // a digit goes to precision only from the precision phases
  assign prec_side = (phase_r == PH_PSTART) || (phase_r == PH_PDIG);
  always_comb begin
    acc_base = '0;
    if (phase_r == PH_WDIG) acc_base = wacc_r;
    if (phase_r == PH_PDIG) acc_base = pacc_r;
  end

  fsp_dec_acc #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_acc (
    .base (acc_base),
    .digit(ch_r[3:0]),
    .sum  (acc_sum)
  );

  // next phase and fields: phases fall through as the byte is consumed
  always_comb begin
    phase_t p;
    logic   done;
    p         = phase_r;
    done      = 1'b0;
    emit      = 1'b0;
    not_req   = 1'b0;
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    wacc_nxt  = wacc_r;
    wstar_nxt = wstar_r;
    pacc_nxt  = pacc_r;
    pstar_nxt = pstar_r;
    len_nxt   = len_r;

    if (p == PH_IDLE) begin
      done = 1'b1;
      if (ch_r == CH_PERCENT) begin
        phase_nxt = PH_FLAG;
        flag_nxt  = FLAG_NONE;
        wacc_nxt  = '0;
        wstar_nxt = 1'b0;
        pacc_nxt  = '0;
        pstar_nxt = 1'b0;
        len_nxt   = LEN_NONE;
      end else begin
        emit    = 1'b1;
        not_req = 1'b1;
      end
    end
    if (!done && p == PH_FLAG) begin
      p = PH_WSTART;
      if (flag_of(ch_r) != FLAG_NONE) begin
        flag_nxt  = flag_of(ch_r);
        phase_nxt = PH_WSTART;
        done      = 1'b1;
      end
    end
    if (!done && p == PH_WSTART) begin
      p = PH_DOT;
      if (ch_r >= CH_ONE && ch_r <= CH_NINE) begin
        wacc_nxt  = acc_sum;
        phase_nxt = PH_WDIG;
        done      = 1'b1;
      end else if (ch_r == CH_STAR) begin
        wstar_nxt = 1'b1;
        phase_nxt = PH_DOT;
        done      = 1'b1;
      end
    end
    if (!done && p == PH_WDIG) begin
      p = PH_DOT;
      if (is_digit(ch_r)) begin
        wacc_nxt  = acc_sum;
        phase_nxt = PH_WDIG;
        done      = 1'b1;
      end
    end
    if (!done && p == PH_DOT) begin
      p = PH_LEN;
      if (ch_r == CH_DOT) begin
        phase_nxt = PH_PSTART;
        done      = 1'b1;
      end
    end
    if (!done && p == PH_PSTART) begin
      p = PH_LEN;
      if (is_digit(ch_r) && prec_side) begin
        pacc_nxt  = acc_sum;
        phase_nxt = PH_PDIG;
        done      = 1'b1;
      end else if (ch_r == CH_STAR) begin
        pstar_nxt = 1'b1;
        phase_nxt = PH_LEN;
        done      = 1'b1;
      end
    end
    if (!done && p == PH_PDIG) begin
      p = PH_LEN;
      if (is_digit(ch_r) && prec_side) begin
        pacc_nxt  = acc_sum;
        phase_nxt = PH_PDIG;
        done      = 1'b1;
      end
    end
    if (!done && p == PH_LEN) begin
      p = PH_SPEC;
      done = 1'b1;
      phase_nxt = PH_SPEC;
      priority if (ch_r == CH_L) phase_nxt = PH_LEN_L;
      else if (ch_r == CH_H) phase_nxt = PH_LEN_H;
      else if (ch_r == CH_J) len_nxt = LEN_J;
      else if (ch_r == CH_Z) len_nxt = LEN_Z;
      else if (ch_r == CH_Q) len_nxt = LEN_Q;
      else done = 1'b0;
    end
    if (!done && p == PH_LEN_L) begin
      p = PH_SPEC;
      if (ch_r == CH_L) begin
        len_nxt   = LEN_LL;
        phase_nxt = PH_SPEC;
        done      = 1'b1;
      end else begin
        len_nxt = LEN_L;
      end
    end
    if (!done && p == PH_LEN_H) begin
      p = PH_SPEC;
      if (ch_r == CH_H) begin
        len_nxt   = LEN_HH;
        phase_nxt = PH_SPEC;
        done      = 1'b1;
      end else begin
        len_nxt = LEN_H;
      end
    end
    // specifier position, any other phase code too
    if (!done) begin
      emit      = 1'b1;
      phase_nxt = PH_IDLE;
    end
  end

  // result fields, low 16 bits of the accumulators
  assign wacc_ext = {16'b0, wacc_r};
  assign pacc_ext = {16'b0, pacc_r};

  always_comb begin
    res_nxt            = '0;
    res_nxt.conversion = ch_r;
    if (not_req) begin
      res_nxt.status = STAT_NOT_REQ;
    end else begin
      res_nxt.status             = STAT_PARSED;
      res_nxt.flag_code          = flag_r;
      res_nxt.width              = wacc_ext[15:0];
      res_nxt.width_from_arg     = wstar_r;
      res_nxt.precision          = pacc_ext[15:0];
      res_nxt.precision_from_arg = pstar_r;
      res_nxt.length_code        = len_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tready) begin
      stage_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      ch_r <= in_tdata;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      flag_r  <= FLAG_NONE;
      wacc_r  <= '0;
      wstar_r <= 1'b0;
      pacc_r  <= '0;
      pstar_r <= 1'b0;
      len_r   <= LEN_NONE;
    end else if (stage_adv) begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      wacc_r  <= wacc_nxt;
      wstar_r <= wstar_nxt;
      pacc_r  <= pacc_nxt;
      pstar_r <= pstar_nxt;
      len_r   <= len_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (stage_adv && emit) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: design/fsp_checker.sv
module fsp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [fsp_pkg::OUT_W-1:0] out_tdata
);
  import fsp_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // a not-a-request item carries only the conversion byte
  a_not_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] == STAT_NOT_REQ) |-> out_tdata[40:1] == '0)
    else $error("not-a-request item has nonzero fields");

  // a star width or precision leaves its decimal value zero
  a_star_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[20] || out_tdata[37]) |->
      (!out_tdata[20] || out_tdata[19:4] == '0) &&
      (!out_tdata[37] || out_tdata[36:21] == '0))
    else $error("star field with nonzero value");

  // after reset both stages are empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> in_tready && !out_tvalid)
    else $error("pipeline not empty after reset");

endmodule

bind format_specifier_parser_unit fsp_checker u_fsp_checker (.*);

FILE: bench/format_specifier_parser_unit_tb.sv
module format_specifier_parser_unit_tb;
  import fsp_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 650;
  localparam int SAT_MAX      = 65535;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;

  format_specifier_parser_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // parser state as the bench sees it
  phase_t      pr_phase = PH_IDLE;
  logic [2:0]  pr_flag  = FLAG_NONE;
  logic [15:0] pr_wid   = '0;
  logic        pr_wstar = 1'b0;
  logic [15:0] pr_prec  = '0;
  logic        pr_pstar = 1'b0;
  logic [2:0]  pr_len   = LEN_NONE;

  // parsed requests still to come out of the block
  result_t pending_specs[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  in_steady   = 1'b0;
  bit  out_steady  = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // decimal accumulate, saturating at the field maximum
  function automatic logic [15:0] add_decimal(input logic [15:0] acc, input logic [7:0] c);
    logic [31:0] v;
    v = 32'(acc) * 32'd10 + 32'(c - CH_ZERO);
    return (v > SAT_MAX) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // advance the parse by one byte; returns 1 when a result item is due (a finished request or a byte outside one)
  function automatic bit parse_char(input logic [7:0] c, output result_t r);
    logic [2:0] f;
    r = '0;
    if (pr_phase == PH_IDLE) begin
      if (c == CH_PERCENT) begin
        pr_flag  = FLAG_NONE;
        pr_wid   = '0;
        pr_wstar = 1'b0;
        pr_prec  = '0;
        pr_pstar = 1'b0;
        pr_len   = LEN_NONE;
        pr_phase = PH_FLAG;
        return 1'b0;
      end
      r.status     = STAT_NOT_REQ;
      r.conversion = c;
      return 1'b1;
    end
    // optional flag
    if (pr_phase == PH_FLAG) begin
      case (c)
        CH_MINUS: f = FLAG_MINUS;
        CH_PLUS:  f = FLAG_PLUS;
        CH_SPACE: f = FLAG_SPACE;
        CH_HASH:  f = FLAG_HASH;
        CH_ZERO:  f = FLAG_ZERO;
        default:  f = FLAG_NONE;
      endcase
      pr_phase = PH_WSTART;
      if (f != FLAG_NONE) begin
        pr_flag = f;
        return 1'b0;
      end
    end
    // width
    if (pr_phase == PH_WSTART) begin
      if (c >= CH_ONE && c <= CH_NINE) begin
        pr_wid   = add_decimal(16'd0, c);
        pr_phase = PH_WDIG;
        return 1'b0;
      end
      pr_phase = PH_DOT;
      if (c == CH_STAR) begin
        pr_wstar = 1'b1;
        return 1'b0;
      end
    end
    if (pr_phase == PH_WDIG) begin
      if (is_dec(c)) begin
        pr_wid = add_decimal(pr_wid, c);
        return 1'b0;
      end
      pr_phase = PH_DOT;
    end
    // precision
    if (pr_phase == PH_DOT) begin
      if (c == CH_DOT) begin
        pr_phase = PH_PSTART;
        return 1'b0;
      end
      pr_phase = PH_LEN;
    end
    if (pr_phase == PH_PSTART) begin
      if (is_dec(c)) begin
        pr_prec  = add_decimal(16'd0, c);
        pr_phase = PH_PDIG;
        return 1'b0;
      end
      pr_phase = PH_LEN;
      if (c == CH_STAR) begin
        pr_pstar = 1'b1;
        return 1'b0;
      end
    end
    if (pr_phase == PH_PDIG) begin
      if (is_dec(c)) begin
        pr_prec = add_decimal(pr_prec, c);
        return 1'b0;
      end
      pr_phase = PH_LEN;
    end
    // length modifier
    if (pr_phase == PH_LEN) begin
      pr_phase = PH_SPEC;
      case (c)
        CH_L: begin pr_phase = PH_LEN_L; return 1'b0; end
        CH_H: begin pr_phase = PH_LEN_H; return 1'b0; end
        CH_J: begin pr_len = LEN_J; return 1'b0; end
        CH_Z: begin pr_len = LEN_Z; return 1'b0; end
        CH_Q: begin pr_len = LEN_Q; return 1'b0; end
        default: ;
      endcase
    end
    if (pr_phase == PH_LEN_L) begin
      pr_phase = PH_SPEC;
      if (c == CH_L) begin
        pr_len = LEN_LL;
        return 1'b0;
      end
      pr_len = LEN_L;
    end
    if (pr_phase == PH_LEN_H) begin
      pr_phase = PH_SPEC;
      if (c == CH_H) begin
        pr_len = LEN_HH;
        return 1'b0;
      end
      pr_len = LEN_H;
    end
    // specifier ends the request
    r.status             = STAT_PARSED;
    r.flag_code          = pr_flag;
    r.width              = pr_wid;
    r.width_from_arg     = pr_wstar;
    r.precision          = pr_prec;
    r.precision_from_arg = pr_pstar;
    r.length_code        = pr_len;
    r.conversion         = c;
    pr_phase = PH_IDLE;
    return 1'b1;
  endfunction

  // send one byte, with a random gap ahead of it
  task automatic send_char(input logic [7:0] c);
    int      gap;
    result_t spec;
    if ($urandom_range(0, 15) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    if (parse_char(c, spec)) pending_specs.push_back(spec);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // hold the input until every parsed request has come out
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_specs.size() != 0);
  endtask

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endtask

  // result side: random stalls, compare each item with the oldest request
  initial begin
    int      stall;
    result_t got;
    result_t want;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata[RES_BITS-1:0];
      if (pending_specs.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_specs.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("flag_code", 32'(want.flag_code), 32'(got.flag_code));
        check_field("width", 32'(want.width), 32'(got.width));
        check_field("width_from_arg", 32'(want.width_from_arg),
                    32'(got.width_from_arg));
        check_field("precision", 32'(want.precision), 32'(got.precision));
        check_field("precision_from_arg", 32'(want.precision_from_arg),
                    32'(got.precision_from_arg));
        check_field("length_code", 32'(want.length_code), 32'(got.length_code));
        check_field("conversion", 32'(want.conversion), 32'(got.conversion));
        check_field("pad", 32'd0, 32'(out_tdata[OUT_W-1:RES_BITS]));
      end
    end
  end

  // lowest and highest byte while idle
  task automatic test_not_request();
    send_char(8'h00);
    send_char(8'hFF);
  endtask

  // minus flag, width and precision from arguments, long long
  task automatic test_star_fields();
    send_text("%-*.*lld");
  endtask

  // a zero right after the percent is a flag, a second zero is the specifier
  task automatic test_zero_after_percent();
    send_text("%00");
  endtask

  // dot with no value, single h, percent as specifier
  task automatic test_dot_without_value();
    send_text("%.h%");
  endtask

  // width beyond the field maximum, q length, top byte as specifier
  task automatic test_saturation();
    send_text("%99999q\377");
  endtask

  task automatic add_digits(ref logic [7:0] req[$], input int first_lo);
    int n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3);
    req.push_back(CH_ZERO + 8'($urandom_range(first_lo, 9)));
    for (int i = 1; i < n; i++) req.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // mostly well-formed requests with random content, some noise and corruption
  task automatic test_random_requests();
    logic [7:0] req[$];
    string      spec_chars;
    int         sent;
    int         drain_at;
    int         kind;
    spec_chars = "diouxXfFeEgGaAcspn%";
    sent       = 0;
    drain_at   = RANDOM_ITEMS / 3;
    while (sent < RANDOM_ITEMS) begin
      req  = {};
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        req.push_back(8'($urandom_range(0, 255)));
      end else begin
        req.push_back(CH_PERCENT);
        case ($urandom_range(0, 5))
          0: req.push_back(CH_MINUS);
          1: req.push_back(CH_PLUS);
          2: req.push_back(CH_SPACE);
          3: req.push_back(CH_HASH);
          4: req.push_back(CH_ZERO);
          default: ;
        endcase
        case ($urandom_range(0, 3))
          0: ;
          1: req.push_back(CH_STAR);
          default: add_digits(req, 1);
        endcase
        if ($urandom_range(0, 1)) begin
          req.push_back(CH_DOT);
          case ($urandom_range(0, 3))
            0: ;
            1: req.push_back(CH_STAR);
            default: add_digits(req, 0);
          endcase
        end
        case ($urandom_range(0, 7))
          1: req.push_back(CH_L);
          2: begin req.push_back(CH_L); req.push_back(CH_L); end
          3: req.push_back(CH_H);
          4: begin req.push_back(CH_H); req.push_back(CH_H); end
          5: req.push_back(CH_J);
          6: req.push_back(CH_Z);
          7: req.push_back(CH_Q);
          default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
          req.push_back(8'($urandom_range(0, 255)));
        else
          req.push_back(spec_chars[$urandom_range(0, spec_chars.len() - 1)]);
        // broken request: one byte replaced at random
        if (kind == 1) req[$urandom_range(0, req.size() - 1)] = 8'($urandom_range(0, 255));
      end
      foreach (req[i]) send_char(req[i]);
      sent += req.size();
      if (sent >= drain_at) begin
        wait_for_results();
        drain_at += RANDOM_ITEMS / 3;
      end
    end
  endtask

  // stimulus and final verdict
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_not_request();
    test_star_fields();
    test_zero_after_percent();
    test_dot_without_value();
    test_saturation();
    test_random_requests();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
